>>> hw/rtl/ird_pkg.sv
// Shared types, constants and pointer helpers for the input restricted deque.
package ird_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned STATUS_W   = 2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 3'd0,
    KIND_POP_NEW  = 3'd1,
    KIND_POP_OLD  = 3'd2,
    KIND_PEEK_NEW = 3'd3,
    KIND_PEEK_OLD = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;     // Request accepted: update pointers and access the RAM.
    logic capture;  // RAM read data is valid: load the result register.
  } cmd_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    ptr_t r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ird_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ird_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ird_ctrl.sv
// Request sequencing state machine for the input restricted deque.
module ird_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ird_pkg::cmd_t cmd_o
);
  import ird_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CAPT = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CAPT;
        end
      end
      ST_CAPT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign cmd_o.exec    = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.capture = (state_q == ST_CAPT);

endmodule

>>> hw/rtl/ird_dp.sv
// Datapath of the input restricted deque: pointers, count, entry RAM and result register.
module ird_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ird_pkg::cmd_t                          cmd_i,
  input  logic [ird_pkg::KIND_W-1:0]             kind_i,
  input  logic signed [ird_pkg::DATA_WIDTH-1:0]  value_i,
  output logic signed [ird_pkg::DATA_WIDTH-1:0]  data_o,
  output logic [ird_pkg::STATUS_W-1:0]           status_o,
  output logic [ird_pkg::CNT_W-1:0]              fill_o
);
  import ird_pkg::*;

  ptr_t    newest_q, newest_d;
  ptr_t    oldest_q, oldest_d;
  cnt_t    cnt_q, cnt_d;
  status_e status_q, status_d;
  logic    rd_q, rd_d;
  logic signed [DATA_WIDTH-1:0] data_q;

  logic    empty, full;
  logic    ram_we, ram_re;
  ptr_t    ram_raddr;
  ptr_t    new_slot;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == CNT_W'(DEPTH));
  assign new_slot = ptr_dec(newest_q);

  always_comb begin
    newest_d  = newest_q;
    oldest_d  = oldest_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    rd_d      = rd_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = oldest_q;
    if (cmd_i.exec) begin
      status_d = STAT_OK;
      rd_d     = 1'b0;
      unique case (kind_i)
        KIND_PUSH: begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            ram_we   = 1'b1;
            newest_d = ptr_inc(newest_q);
            cnt_d    = cnt_q + CNT_W'(1);
          end
        end
        KIND_POP_NEW, KIND_PEEK_NEW: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rd_d      = 1'b1;
            ram_raddr = new_slot;
            if (kind_i == KIND_POP_NEW) begin
              newest_d = new_slot;
              cnt_d    = cnt_q - CNT_W'(1);
              // When the last entry leaves, both ends meet again.
              if (cnt_q == CNT_W'(1)) begin
                oldest_d = new_slot;
              end
            end
          end
        end
        KIND_POP_OLD, KIND_PEEK_OLD: begin
          if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            ram_re    = 1'b1;
            rd_d      = 1'b1;
            ram_raddr = oldest_q;
            if (kind_i == KIND_POP_OLD) begin
              oldest_d = ptr_inc(oldest_q);
              cnt_d    = cnt_q - CNT_W'(1);
              if (cnt_q == CNT_W'(1)) begin
                newest_d = ptr_inc(oldest_q);
              end
            end
          end
        end
        default: begin
          // Unused request kinds leave the store untouched.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q <= '0;
      oldest_q <= '0;
      cnt_q    <= '0;
      status_q <= STAT_OK;
      rd_q     <= 1'b0;
    end else begin
      newest_q <= newest_d;
      oldest_q <= oldest_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      rd_q     <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      data_q <= rd_q ? $signed(ram_rdata) : '0;
    end
  end

  ird_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (newest_q),
    .wdata_i (value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign data_o   = data_q;
  assign status_o = status_q;
  assign fill_o   = cnt_q;

endmodule

>>> hw/rtl/input_restricted_deque_unit.sv
// Top level of the input restricted deque: controller and datapath.
//
// A 16-entry store of signed 32-bit values that takes values at one end and
// returns them from either end, so it serves as a stack (newest entry) or a
// queue (oldest entry). Each request is a push, a pop or a peek, and each
// request yields exactly one result with the data, a status (ok, empty, or
// full with the push refused) and the fill after the request. Requests are
// handled one at a time: a request is accepted while the pointers and count
// update and the entry RAM is accessed, the registered RAM read is captured
// in the next cycle, and the result is then presented and held until it is
// taken. A new request is accepted only after the last result has been
// taken; this follows from the registered read port of the entry RAM and
// from holding the result until it is taken. The store needs no clearing
// after reset; an entry is only read once it has been written.
module input_restricted_deque_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [ird_pkg::KIND_W-1:0]             kind_i,
  input  logic signed [ird_pkg::DATA_WIDTH-1:0]  value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ird_pkg::DATA_WIDTH-1:0]  data_o,
  output logic [ird_pkg::STATUS_W-1:0]           status_o,
  output logic [ird_pkg::CNT_W-1:0]              fill_o
);
  import ird_pkg::*;

  cmd_t cmd;

  ird_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ird_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .kind_i   (kind_i),
    .value_i  (value_i),
    .data_o   (data_o),
    .status_o (status_o),
    .fill_o   (fill_o)
  );

endmodule

>>> dv/ird_result_checker.sv
// Checker for the input restricted deque: predicts each result and compares it.
`timescale 1ns / 1ps

module ird_result_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic [ird_pkg::KIND_W-1:0]             kind_i,
  input  logic signed [ird_pkg::DATA_WIDTH-1:0]  value_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic signed [ird_pkg::DATA_WIDTH-1:0]  data_i,
  input  logic [ird_pkg::STATUS_W-1:0]           status_i,
  input  logic [ird_pkg::CNT_W-1:0]              fill_i,
  output int unsigned                            fail_count_o,
  output int unsigned                            pending_o
);
  import ird_pkg::*;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] data;
    status_e                      status;
    cnt_t                         fill;
  } deque_result_t;

  logic signed [DATA_WIDTH-1:0] entries [DEPTH];
  ptr_t                         write_slot;   // Slot the next push fills.
  ptr_t                         oldest_slot;
  cnt_t                         held;
  deque_result_t                expected_results [$];
  int unsigned                  mismatches = 0;

  // Applies one request to the shadow store and returns the result it must give.
  task automatic serve_request(input logic [KIND_W-1:0] kind,
                               input logic signed [DATA_WIDTH-1:0] value,
                               output deque_result_t res);
    ptr_t slot;
    res.data   = '0;
    res.status = STAT_OK;
    case (kind)
      KIND_PUSH: begin
        if (held == CNT_W'(DEPTH)) begin
          res.status = STAT_FULL;
        end else begin
          entries[write_slot] = value;
          write_slot = ptr_t'((int'(write_slot) + 1) % DEPTH);
          held = held + 1'b1;
        end
      end
      KIND_POP_NEW, KIND_PEEK_NEW: begin
        if (held == '0) begin
          res.status = STAT_EMPTY;
        end else begin
          slot = ptr_t'((int'(write_slot) + DEPTH - 1) % DEPTH);
          res.data = entries[slot];
          if (kind == KIND_POP_NEW) begin
            write_slot = slot;
            held = held - 1'b1;
            // An emptied store has both ends at the same slot.
            if (held == '0) begin
              oldest_slot = write_slot;
            end
          end
        end
      end
      KIND_POP_OLD, KIND_PEEK_OLD: begin
        if (held == '0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.data = entries[oldest_slot];
          if (kind == KIND_POP_OLD) begin
            oldest_slot = ptr_t'((int'(oldest_slot) + 1) % DEPTH);
            held = held - 1'b1;
            if (held == '0) begin
              write_slot = oldest_slot;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.fill = held;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t due;
    if (!rst_ni) begin
      write_slot  = '0;
      oldest_slot = '0;
      held        = '0;
      expected_results.delete();
    end else begin
      // The request is applied first: a result taken at the same edge is older.
      if (in_valid_i && in_ready_i) begin
        serve_request(kind_i, value_i, due);
        expected_results.push_back(due);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: data %0d status %0d fill %0d",
                 data_i, status_i, fill_i);
          mismatches++;
        end else begin
          due = expected_results.pop_front();
          if (data_i !== due.data) begin
            $error("data: expected %0d, got %0d", due.data, data_i);
            mismatches++;
          end
          if (status_i !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status_i);
            mismatches++;
          end
          if (fill_i !== due.fill) begin
            $error("fill: expected %0d, got %0d", due.fill, fill_i);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_results.size();
  end

endmodule

>>> dv/tb_input_restricted_deque_unit.sv
// Testbench top for the input restricted deque: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_input_restricted_deque_unit;
  import ird_pkg::*;

  localparam int unsigned          RANDOM_REQUESTS   = 900;
  localparam int unsigned          CYCLE_LIMIT       = 200000;
  localparam int unsigned          DRAIN_CYCLES      = 10;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_FIRST = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_MID   = 3'd6;
  localparam logic [KIND_W-1:0]    KIND_UNUSED_LAST  = 3'd7;

  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } traffic_mix_e;

  logic                          clk_i;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [KIND_W-1:0]             kind      = KIND_PUSH;
  logic signed [DATA_WIDTH-1:0]  value     = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [DATA_WIDTH-1:0]  data;
  logic [STATUS_W-1:0]           status;
  logic [CNT_W-1:0]              fill;
  int unsigned                   fail_count;
  int unsigned                   pending;
  int unsigned                   cycles    = 0;
  bit                            steady    = 1'b0;  // No idling on either side.

  input_restricted_deque_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .data_o      (data),
    .status_o    (status),
    .fill_o      (fill)
  );

  ird_result_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (kind),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .data_i       (data),
    .status_i     (status),
    .fill_i       (fill),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: a random stall before each result, then ready until it is taken.
  initial begin
    int unsigned stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  task automatic send_request(input logic [KIND_W-1:0] k,
                              input logic signed [DATA_WIDTH-1:0] v);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'sh7fff_ffff;
      1:       v = 32'sh8000_0000;
      2:       v = '0;
      3:       v = -32'sd1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind(input int unsigned push_pct);
    logic [KIND_W-1:0] k;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      k = KIND_W'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
    end else if (r < 3 + push_pct) begin
      k = KIND_PUSH;
    end else begin
      case ($urandom_range(0, 3))
        0:       k = KIND_POP_NEW;
        1:       k = KIND_POP_OLD;
        2:       k = KIND_PEEK_NEW;
        default: k = KIND_PEEK_OLD;
      endcase
    end
    return k;
  endfunction

  initial begin
    int unsigned  sent;
    int unsigned  burst;
    int unsigned  push_pct;
    traffic_mix_e mix;

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Every read kind on an empty store.
    send_request(KIND_POP_NEW, 32'sd5);
    send_request(KIND_POP_OLD, -32'sd5);
    send_request(KIND_PEEK_NEW, '0);
    send_request(KIND_PEEK_OLD, 32'sh7fff_ffff);
    // Extreme values, then both ends read back without removal.
    send_request(KIND_PUSH, 32'sh7fff_ffff);
    send_request(KIND_PUSH, 32'sh8000_0000);
    send_request(KIND_PUSH, '0);
    send_request(KIND_PUSH, -32'sd1);
    send_request(KIND_PEEK_NEW, '0);
    send_request(KIND_PEEK_OLD, '0);
    // Unused kinds leave the store alone.
    send_request(KIND_UNUSED_FIRST, 32'sh1234_5678);
    send_request(KIND_UNUSED_MID, -32'sd1);
    send_request(KIND_UNUSED_LAST, 32'sh8000_0000);
    send_request(KIND_POP_NEW, '0);
    send_request(KIND_POP_OLD, '0);
    send_request(KIND_POP_OLD, '0);
    // The last entry leaves from the newest end, then from the oldest end.
    send_request(KIND_POP_NEW, '0);
    send_request(KIND_PEEK_OLD, '0);
    send_request(KIND_PUSH, 32'sh5a5a_a5a5);
    send_request(KIND_POP_OLD, '0);
    send_request(KIND_PEEK_NEW, '0);
    send_request(KIND_PUSH, -32'sd42);
    send_request(KIND_PEEK_NEW, '0);

    // Fill past the top so that refused pushes are seen early.
    for (int i = 0; i < 20; i++) begin
      send_request(KIND_PUSH, pick_value());
    end
    sent = 20;

    while (sent < RANDOM_REQUESTS) begin
      mix    = traffic_mix_e'($urandom_range(0, 2));
      steady = ($urandom_range(0, 3) == 0);
      burst  = $urandom_range(8, 40);
      case (mix)
        MIX_FILL:  push_pct = 80;
        MIX_DRAIN: push_pct = 15;
        default:   push_pct = 48;
      endcase
      for (int i = 0; i < burst; i++) begin
        send_request(pick_kind(push_pct), pick_value());
      end
      sent += burst;
    end
    in_valid <= 1'b0;
    steady   = 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
